// ===== rtl/core/ucfs_pkg.sv =====
// Package with the shared types and constants of the UART command frame supervisor.
package ucfs_pkg;

  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_STEP    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [2:0] MODE_INIT     = 3'd0;
  localparam logic [2:0] MODE_SELFTEST = 3'd1;
  localparam logic [2:0] MODE_RUN      = 3'd2;
  localparam logic [2:0] MODE_LINKLOSS = 3'd3;
  localparam logic [2:0] MODE_ERROR    = 3'd4;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_CHECKSUM = 2'd1;
  localparam logic [1:0] FAULT_LINKLOSS = 2'd2;

  localparam logic [1:0] CFG_INIT_WAIT     = 2'd0;
  localparam logic [1:0] CFG_SELFTEST_WAIT = 2'd1;
  localparam logic [1:0] CFG_LINK_TIMEOUT  = 2'd2;

  localparam logic [7:0]  CMD_TOGGLE   = 8'hA1;
  localparam logic [7:0]  CMD_LINKLOSS = 8'hE0;
  localparam logic [31:0] TICK_STEP    = 32'd10;
  localparam int unsigned FRAME_LEN    = 4;

  localparam logic [31:0] INIT_WAIT_RST     = 32'd20;
  localparam logic [31:0] SELFTEST_WAIT_RST = 32'd80;
  localparam logic [31:0] LINK_TIMEOUT_RST  = 32'd500;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } ucfs_in_t;

  typedef struct packed {
    logic [2:0] sys_mode;
    logic       led_ok;
    logic       led_err;
    logic [1:0] fault_code;
    logic [4:0] queued_bytes;
    logic       byte_dropped;
  } ucfs_out_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } ucfs_fifo_req_t;

endpackage

// ===== rtl/core/ucfs_rx_fifo.sv =====
// Receive byte ring FIFO held in a synchronous memory with a registered read port.
module ucfs_rx_fifo
  import ucfs_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16,
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH),
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ucfs_fifo_req_t   req_i,
  output logic [7:0]       rd_data_o,
  output logic [CNT_W-1:0] count_o,
  output logic             full_o
);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       rd_data_q;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (count_q == CNT_W'(FIFO_DEPTH));
  assign do_push = req_i.push && !full_o;

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = req_i.pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNT_W'(do_push) - CNT_W'(req_i.pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= req_i.data;
    end
    if (req_i.pop) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign rd_data_o = rd_data_q;
  assign count_o   = count_q;

endmodule

// ===== rtl/core/uart_command_frame_supervisor.sv =====
// Top level of the UART command frame supervisor: event handling, mode control, result buffer.
// A received byte, a tick or an unused operation word is taken and its result word is
// registered into the result buffer. A main step with the pending flag set and at least four
// queued bytes pops a four-byte frame through the single read port of the receive store,
// one byte a cycle, and stalls the input until the frame is checked; other main steps do not.
// Results are buffered in two entries, so one new word is taken while a result still waits.
// The user writes the three thresholds on the plain write port only while the block is idle.
module uart_command_frame_supervisor
  import ucfs_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ucfs_in_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ucfs_out_t   out_word_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       beat_q, beat_d;
  logic [7:0]       frame_q [3];
  logic [7:0]       frame_d [3];
  logic [2:0]       mode_q, mode_d, mode_step;
  logic [31:0]      tick_q, tick_d;
  logic             pend_q, pend_d;
  logic             ok_q, ok_d;
  logic             err_q, err_d;
  logic [1:0]       fault_q, fault_d;
  logic [31:0]      init_wait_q, selftest_wait_q, link_timeout_q;
  ucfs_out_t        out_q, out_d, spare_q, spare_d, res;
  logic             out_valid_q, out_valid_d, spare_valid_q, spare_valid_d;
  logic             res_valid, dropped, accept, out_pop;
  ucfs_fifo_req_t   fifo_req;
  logic [7:0]       rd_data;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_after;
  logic [31:0]      count_wide;
  logic             full;
  logic [7:0]       chk;

  ucfs_rx_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_rx_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (fifo_req),
    .rd_data_o(rd_data),
    .count_o  (count),
    .full_o   (full)
  );

  assign in_stall_o = (state_q != S_IDLE) || spare_valid_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_pop    = out_valid_q && !out_stall_i;

  always_comb begin
    mode_step = mode_q;
    if (mode_step == MODE_INIT && tick_q > init_wait_q) begin
      mode_step = MODE_SELFTEST;
    end
    if (mode_step == MODE_SELFTEST && tick_q > selftest_wait_q) begin
      mode_step = MODE_RUN;
    end
    if (mode_step == MODE_RUN && tick_q > link_timeout_q) begin
      mode_step = MODE_LINKLOSS;
    end
  end

  always_comb begin
    state_d   = state_q;
    beat_d    = beat_q;
    frame_d   = frame_q;
    mode_d    = mode_q;
    tick_d    = tick_q;
    pend_d    = pend_q;
    ok_d      = ok_q;
    err_d     = err_q;
    fault_d   = fault_q;
    res_valid = 1'b0;
    dropped   = 1'b0;
    fifo_req  = '{push: 1'b0, pop: 1'b0, data: in_word_i.rx_byte};
    chk       = frame_q[0] ^ frame_q[1] ^ frame_q[2];
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_word_i.operation)
            OP_RX_BYTE: begin
              fifo_req.push = 1'b1;
              dropped       = full;
              pend_d        = 1'b1;
              res_valid     = 1'b1;
            end
            OP_TICK: begin
              tick_d    = tick_q + TICK_STEP;
              res_valid = 1'b1;
            end
            OP_STEP: begin
              mode_d = mode_step;
              err_d  = err_q || (fault_q != FAULT_NONE);
              if (pend_q) begin
                pend_d = 1'b0;
              end
              if (pend_q && count >= CNT_W'(FRAME_LEN)) begin
                fifo_req.pop = 1'b1;
                state_d      = S_FETCH;
                beat_d       = 2'd0;
              end else begin
                res_valid = 1'b1;
              end
            end
            OP_NONE: begin
              res_valid = 1'b1;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (beat_q != 2'd3) begin
          frame_d[beat_q] = rd_data;
          beat_d          = beat_q + 2'd1;
          fifo_req.pop    = 1'b1;
        end else begin
          if (chk != rd_data) begin
            fault_d = FAULT_CHECKSUM;
            mode_d  = MODE_ERROR;
          end else begin
            if (frame_q[0] == CMD_TOGGLE) begin
              ok_d = !ok_q;
            end
            if (frame_q[0] == CMD_LINKLOSS) begin
              fault_d = FAULT_LINKLOSS;
              mode_d  = MODE_LINKLOSS;
            end
          end
          err_d     = err_q || (fault_d != FAULT_NONE);
          state_d   = S_IDLE;
          res_valid = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_after      = count + CNT_W'(fifo_req.push && !full);
    count_wide       = 32'(count_after);
    res.sys_mode     = mode_d;
    res.led_ok       = ok_d;
    res.led_err      = err_d;
    res.fault_code   = fault_d;
    res.queued_bytes = count_wide[4:0];
    res.byte_dropped = dropped;
  end

  always_comb begin
    out_d         = out_q;
    out_valid_d   = out_valid_q;
    spare_d       = spare_q;
    spare_valid_d = spare_valid_q;
    if (out_pop) begin
      if (spare_valid_q) begin
        out_d         = spare_q;
        out_valid_d   = 1'b1;
        spare_valid_d = res_valid;
        if (res_valid) begin
          spare_d = res;
        end
      end else begin
        out_valid_d = res_valid;
        if (res_valid) begin
          out_d = res;
        end
      end
    end else if (res_valid) begin
      if (!out_valid_q) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        spare_d       = res;
        spare_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      beat_q          <= 2'd0;
      frame_q         <= '{default: 8'd0};
      mode_q          <= MODE_INIT;
      tick_q          <= '0;
      pend_q          <= 1'b0;
      ok_q            <= 1'b0;
      err_q           <= 1'b0;
      fault_q         <= FAULT_NONE;
      init_wait_q     <= INIT_WAIT_RST;
      selftest_wait_q <= SELFTEST_WAIT_RST;
      link_timeout_q  <= LINK_TIMEOUT_RST;
      out_q           <= '0;
      spare_q         <= '0;
      out_valid_q     <= 1'b0;
      spare_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      beat_q        <= beat_d;
      frame_q       <= frame_d;
      mode_q        <= mode_d;
      tick_q        <= tick_d;
      pend_q        <= pend_d;
      ok_q          <= ok_d;
      err_q         <= err_d;
      fault_q       <= fault_d;
      out_q         <= out_d;
      spare_q       <= spare_d;
      out_valid_q   <= out_valid_d;
      spare_valid_q <= spare_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_INIT_WAIT:     init_wait_q     <= cfg_wdata_i;
          CFG_SELFTEST_WAIT: selftest_wait_q <= cfg_wdata_i;
          CFG_LINK_TIMEOUT:  link_timeout_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
